@@ rtl/clce_pkg.sv @@
// Shared types, codes and constants of the character LCD cursor engine.
`default_nettype none

package clce_pkg;

    // Default sizes of the display geometry
    localparam int MAX_COLUMNS_DEF = 40;
    localparam int MAX_ROWS_DEF    = 4;

    // Field and register widths
    localparam int COL_W       = 6;
    localparam int ROW_W       = 2;
    localparam int COLCNT_W    = 6;
    localparam int ROWCNT_W    = 3;
    localparam int BASE_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int OP_W        = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;
    localparam int S_DATA_W    = 24;

    // Input operation codes
    localparam logic [OP_W-1:0] OP_CHAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_EOS    = 3'd1;
    localparam logic [OP_W-1:0] OP_SETCUR = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_HOME   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW0_BASE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1_BASE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2_BASE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW3_BASE    = 3'd5;

    // Controller bytes
    localparam logic [BYTE_W-1:0] NL_CODE      = 8'h0A;
    localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_HOME     = 8'h02;

    // Register reset values
    localparam logic [COLCNT_W-1:0] COLUMN_COUNT_RST = 6'd16;
    localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST    = 3'd2;
    localparam logic [BASE_W-1:0]   ROW0_BASE_RST    = 7'h00;
    localparam logic [BASE_W-1:0]   ROW1_BASE_RST    = 7'h40;
    localparam logic [BASE_W-1:0]   ROW2_BASE_RST    = 7'h10;
    localparam logic [BASE_W-1:0]   ROW3_BASE_RST    = 7'h50;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Classified work item kinds
    typedef enum logic [2:0] {
        KIND_CHAR,
        KIND_NEWLINE,
        KIND_EOS,
        KIND_SETCUR,
        KIND_CLEAR,
        KIND_HOME
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] char_code;
        logic [BYTE_W-1:0] want_column;
        logic [BYTE_W-1:0] want_row;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_ADDR,
        ST_DATA,
        ST_CMD
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/clce_front.sv @@
// Front end: accepts input transfers, classifies them and pushes work items.
`default_nettype none

module clce_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [clce_pkg::S_DATA_W-1:0]   s_tdata,   // char_code, want_column, want_row
    input  logic [clce_pkg::OP_W-1:0]       s_tuser,   // op
    input  clce_pkg::q_status_t             q_status,
    output logic                            push,
    output clce_pkg::item_t                 push_item
);
    import clce_pkg::*;

    logic known_op;

    // Take a transfer whenever the queue has room
    assign s_tready = !q_status.full;

    // Classify the operation; unknown codes are dropped
    always_comb
    begin
        push_item.char_code   = s_tdata[7:0];
        push_item.want_column = s_tdata[15:8];
        push_item.want_row    = s_tdata[23:16];
        push_item.kind        = KIND_CHAR;
        known_op              = 1'b1;
        unique case (s_tuser)
            OP_CHAR:
            begin
                if (s_tdata[7:0] == NL_CODE)
                begin
                    push_item.kind = KIND_NEWLINE;
                end
                else
                begin
                    push_item.kind = KIND_CHAR;
                end
            end
            OP_EOS:    push_item.kind = KIND_EOS;
            OP_SETCUR: push_item.kind = KIND_SETCUR;
            OP_CLEAR:  push_item.kind = KIND_CLEAR;
            OP_HOME:   push_item.kind = KIND_HOME;
            default:   known_op = 1'b0;
        endcase
    end

    assign push = s_tvalid && s_tready && known_op;

endmodule

`default_nettype wire

@@ rtl/clce_queue.sv @@
// Short work queue between the front end and the back end.
`default_nettype none

module clce_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  clce_pkg::item_t     push_item,
    input  logic                pop,
    output clce_pkg::item_t     head_item,
    output clce_pkg::q_status_t status
);
    import clce_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

@@ rtl/clce_back.sv @@
// Back end: holds the cursor and configuration, sequences controller bytes.
`default_nettype none

module clce_back #(
    parameter int MAX_COLUMNS = clce_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = clce_pkg::MAX_ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [clce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  clce_pkg::item_t                  q_item,
    input  clce_pkg::q_status_t              q_status,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [clce_pkg::BYTE_W-1:0]      m_tdata,   // bus_byte
    output logic                             m_tuser,   // is_data
    output logic                             m_tlast
);
    import clce_pkg::*;

    localparam int CDIV_W = COLCNT_W + BYTE_W;
    localparam int RDIV_W = ROWCNT_W + BYTE_W;

    // Configuration registers
    logic [COLCNT_W-1:0] column_count_reg;
    logic [ROWCNT_W-1:0] row_count_reg;
    logic [BASE_W-1:0]   row_base_reg [4];

    // Sequencer and cursor
    back_state_t       state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    kind_t             kind_reg, kind_next;
    logic [BYTE_W-1:0] char_reg, char_next;
    logic [BYTE_W-1:0] col_rem_reg, col_rem_next;
    logic [BYTE_W-1:0] row_rem_reg, row_rem_next;
    logic [2:0]        step_reg, step_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_is_data_reg, out_is_data_next;
    logic              out_last_reg, out_last_next;

    logic [COLCNT_W-1:0] cols;
    logic [ROWCNT_W-1:0] rows;
    logic                out_free;
    logic                out_load;
    logic [BASE_W-1:0]   addr;
    logic                col_at_end;
    logic [CDIV_W-1:0]   col_div_sh;
    logic [RDIV_W-1:0]   row_div_sh;
    logic [BYTE_W-1:0]   col_rem_step;
    logic [BYTE_W-1:0]   row_rem_step;

    // Next row, modulo the row count
    function automatic logic [ROW_W-1:0] row_wrap(input logic [ROW_W-1:0] r,
                                                  input logic [ROWCNT_W-1:0] n);
        logic [ROWCNT_W-1:0] v;
        v = {1'b0, r} + ROWCNT_W'(1);
        for (int i = 0; i < 4; i++)
        begin
            if (v >= n)
            begin
                v = v - n;
            end
        end
        return v[ROW_W-1:0];
    endfunction

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= COLUMN_COUNT_RST;
            row_count_reg    <= ROW_COUNT_RST;
            row_base_reg[0]  <= ROW0_BASE_RST;
            row_base_reg[1]  <= ROW1_BASE_RST;
            row_base_reg[2]  <= ROW2_BASE_RST;
            row_base_reg[3]  <= ROW3_BASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLUMN_COUNT: column_count_reg <= cfg_data[COLCNT_W-1:0];
                REG_ROW_COUNT:    row_count_reg    <= cfg_data[ROWCNT_W-1:0];
                REG_ROW0_BASE:    row_base_reg[0]  <= cfg_data[BASE_W-1:0];
                REG_ROW1_BASE:    row_base_reg[1]  <= cfg_data[BASE_W-1:0];
                REG_ROW2_BASE:    row_base_reg[2]  <= cfg_data[BASE_W-1:0];
                REG_ROW3_BASE:    row_base_reg[3]  <= cfg_data[BASE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp the geometry to usable sizes
    always_comb
    begin
        if (column_count_reg == '0)
        begin
            cols = COLCNT_W'(1);
        end
        else if ({1'b0, column_count_reg} > (COLCNT_W + 1)'(MAX_COLUMNS))
        begin
            cols = COLCNT_W'(MAX_COLUMNS);
        end
        else
        begin
            cols = column_count_reg;
        end

        if (row_count_reg == '0)
        begin
            rows = ROWCNT_W'(1);
        end
        else if ({1'b0, row_count_reg} > (ROWCNT_W + 1)'(MAX_ROWS))
        begin
            rows = ROWCNT_W'(MAX_ROWS);
        end
        else
        begin
            rows = row_count_reg;
        end
    end

    // Display address, column wrap and one remainder step
    assign addr       = row_base_reg[row_reg] + {1'b0, col_reg};
    assign col_at_end = ({1'b0, col_reg} + (COL_W + 1)'(1)) >= {1'b0, cols};
    assign col_div_sh = {{BYTE_W{1'b0}}, cols} << step_reg;
    assign row_div_sh = {{BYTE_W{1'b0}}, rows} << step_reg;

    always_comb
    begin
        col_rem_step = col_rem_reg;
        row_rem_step = row_rem_reg;
        if ({{COLCNT_W{1'b0}}, col_rem_reg} >= col_div_sh)
        begin
            col_rem_step = col_rem_reg - col_div_sh[BYTE_W-1:0];
        end
        if ({{ROWCNT_W{1'b0}}, row_rem_reg} >= row_div_sh)
        begin
            row_rem_step = row_rem_reg - row_div_sh[BYTE_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    unique case (q_item.kind)
                        KIND_CHAR, KIND_EOS: state_next = ST_ADDR;
                        KIND_SETCUR:         state_next = ST_MOD;
                        KIND_CLEAR, KIND_HOME: state_next = ST_CMD;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MOD:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                if (out_free)
                begin
                    state_next = (kind_reg == KIND_CHAR) ? ST_DATA : ST_IDLE;
                end
            end
            ST_DATA, ST_CMD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        q_pop            = 1'b0;
        col_next         = col_reg;
        row_next         = row_reg;
        kind_next        = kind_reg;
        char_next        = char_reg;
        col_rem_next     = col_rem_reg;
        row_rem_next     = row_rem_reg;
        step_next        = step_reg;
        out_load         = 1'b0;
        out_byte_next    = out_byte_reg;
        out_is_data_next = out_is_data_reg;
        out_last_next    = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop     = 1'b1;
                    kind_next = q_item.kind;
                    char_next = q_item.char_code;
                    unique case (q_item.kind)
                        KIND_NEWLINE:
                        begin
                            row_next = row_wrap(row_reg, rows);
                            col_next = '0;
                        end
                        KIND_EOS:
                        begin
                            if (col_reg >= cols)
                            begin
                                col_next = cols - COL_W'(1);
                            end
                        end
                        KIND_SETCUR:
                        begin
                            col_rem_next = q_item.want_column;
                            row_rem_next = q_item.want_row;
                            step_next    = 3'd7;
                        end
                        KIND_CLEAR, KIND_HOME:
                        begin
                            col_next = '0;
                            row_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOD:
            begin
                col_rem_next = col_rem_step;
                row_rem_next = row_rem_step;
                step_next    = step_reg - 3'd1;
                if (step_reg == '0)
                begin
                    col_next = col_rem_step[COL_W-1:0];
                    row_next = row_rem_step[ROW_W-1:0];
                end
            end
            ST_ADDR:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_byte_next    = CMD_SET_ADDR | {1'b0, addr};
                    out_is_data_next = 1'b0;
                    out_last_next    = (kind_reg != KIND_CHAR);
                    if (kind_reg == KIND_CHAR)
                    begin
                        if (col_at_end)
                        begin
                            col_next = '0;
                            row_next = row_wrap(row_reg, rows);
                        end
                        else
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                end
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_byte_next    = char_reg;
                    out_is_data_next = 1'b1;
                    out_last_next    = 1'b1;
                end
            end
            ST_CMD:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_byte_next    = (kind_reg == KIND_CLEAR) ? CMD_CLEAR : CMD_HOME;
                    out_is_data_next = 1'b0;
                    out_last_next    = 1'b1;
                end
            end
            default: ;
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            kind_reg      <= KIND_CHAR;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            kind_reg      <= kind_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg        <= char_next;
        col_rem_reg     <= col_rem_next;
        row_rem_reg     <= row_rem_next;
        out_byte_reg    <= out_byte_next;
        out_is_data_reg <= out_is_data_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_is_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // Only pop a waiting item, and only from the idle state
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE) && !q_status.empty)
        else $error("queue popped outside idle or while empty");

    // A data byte only follows the address command of a character
    a_data_char: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> (kind_reg == KIND_CHAR))
        else $error("data byte stage entered for a non-character item");

    // The remainder unit leaves the column inside the row
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADDR) && ($past(state_reg) == ST_MOD) |-> (col_reg < cols))
        else $error("set-cursor column not reduced below the column count");

    // A data byte is always the final transfer of its item
    a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_is_data_reg |-> out_last_reg)
        else $error("data byte without last flag");
`endif

endmodule

`default_nettype wire

@@ rtl/char_lcd_cursor_engine_core.sv @@
// Top level of the character LCD cursor engine.
//
// Text events arrive on the s_ stream: s_tuser carries the operation and
// s_tdata the character and the requested cursor position. Controller bytes
// leave on the m_ stream, with m_tuser high for a data byte (RS high) and
// m_tlast on the final byte of each event. Geometry and row base addresses
// are written by the user through cfg_we / cfg_index / cfg_data only while the
// block is idle, which the block does not enforce. The front end classifies
// each event and queues it (two entries), so input transfers continue while
// the back end or the receiver is stalled. The back end sequencer pops one
// event at a time: a character passes through the address and data states;
// end of string, clear and home through one output state; a newline is done
// in idle; set-cursor runs its column and row remainders through an 8-step
// shift-and-subtract unit, then the address state. A stalled receiver holds
// the output register and the sequencer waits on it. Reset clears the cursor,
// queue and output register, restores default geometry; no clearing pass.
`default_nettype none

module char_lcd_cursor_engine_core #(
    parameter int MAX_COLUMNS = clce_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = clce_pkg::MAX_ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [clce_pkg::S_DATA_W-1:0]    s_tdata,   // char_code, want_column, want_row
    input  logic [clce_pkg::OP_W-1:0]        s_tuser,   // op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [clce_pkg::BYTE_W-1:0]      m_tdata,   // bus_byte
    output logic                             m_tuser,   // is_data
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [clce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clce_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import clce_pkg::*;

    logic      push;
    item_t     push_item;
    logic      pop;
    item_t     head_item;
    q_status_t q_status;

    clce_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    clce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    clce_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_item    (head_item),
        .q_status  (q_status),
        .q_pop     (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
